[hw/rtl/pfd_pkg.sv]
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants for the pixel frame dump framer.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam logic [7:0] MARK_FRAME = 8'd1;
  localparam logic [7:0] MARK_ROW   = 8'd2;
  localparam logic [7:0] MARK_END   = 8'd3;
  localparam logic [7:0] PIX_LOW    = 8'd16;
  localparam logic [7:0] PIX_HIGH   = 8'd240;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ALL_CHANNELS = 2'd2,
    REG_LED_AUTO     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    LED_NONE = 2'd0,
    LED_ON   = 2'd1,
    LED_OFF  = 2'd2
  } led_t;

  // result slots of one item, sent lowest first
  localparam int SLOT_FRAME  = 0;
  localparam int SLOT_WIDTH  = 1;
  localparam int SLOT_HEIGHT = 2;
  localparam int SLOT_ROW    = 3;
  localparam int SLOT_PIXEL  = 4;
  localparam int SLOT_END    = 5;
  localparam int NUM_SLOTS   = 6;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    logic [7:0]           pixel;
    logic [7:0]           width;
    logic [7:0]           height;
    led_t                 row_led;
  } item_t;

endpackage

[hw/rtl/pixel_frame_dump_framer.sv]
// ----------------------------------------------------------------------------
// pixel_frame_dump_framer
// Frames camera pixel bytes for a serial link: header, row markers, clamped
// pixels and an end marker, with LED commands on the markers.
// ----------------------------------------------------------------------------
// path: an accepted byte is held as an item in pfd_emit; each result leaves
//   the single output port from a register, one per cycle unless out_ready
//   stalls; a new item is taken with the last result, so pixels keep pace
// reset: synchronous active-low; counters cleared, registers to 80/143/1/1
// ----------------------------------------------------------------------------
module pixel_frame_dump_framer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic [1:0] out_led_command
);
  import pfd_pkg::*;

  logic [7:0] frame_width_r;
  logic [7:0] frame_height_r;
  logic       all_channels_r;
  logic       led_auto_r;
  logic [9:0] col_r;
  logic [9:0] col_nxt;
  logic [7:0] row_r;
  logic [7:0] row_nxt;

  logic [7:0]  width;
  logic [7:0]  height;
  logic [9:0]  row_len;
  logic        row_wrap;
  logic        frame_wrap;
  logic        accept;
  logic        item_ready;
  item_t       item;

  assign width   = (frame_width_r == 8'd0) ? 8'd1 : frame_width_r;
  assign height  = (frame_height_r == 8'd0) ? 8'd1 : frame_height_r;
  assign row_len = all_channels_r ? ({1'b0, width, 1'b0} + {2'b00, width})
                                  : {2'b00, width};
  assign row_wrap   = ({1'b0, col_r} + 11'd1) >= {1'b0, row_len};
  assign frame_wrap = ({1'b0, row_r} + 9'd1) >= {1'b0, height};
  assign accept     = in_valid && in_ready;
  assign in_ready   = item_ready;

  always_comb begin
    item.slots              = '0;
    item.slots[SLOT_FRAME]  = (col_r == '0) && (row_r == '0);
    item.slots[SLOT_WIDTH]  = (col_r == '0) && (row_r == '0);
    item.slots[SLOT_HEIGHT] = (col_r == '0) && (row_r == '0);
    item.slots[SLOT_ROW]    = (col_r == '0);
    item.slots[SLOT_PIXEL]  = 1'b1;
    item.slots[SLOT_END]    = row_wrap && frame_wrap;
    item.width  = width;
    item.height = height;
    if (!led_auto_r) begin
      item.row_led = LED_NONE;
    end else if (row_r[1:0] == 2'b00) begin
      item.row_led = LED_ON;
    end else begin
      item.row_led = LED_OFF;
    end
    // keep pixels clear of the marker codes
    if (in_pixel_byte < PIX_LOW) begin
      item.pixel = PIX_LOW;
    end else if (in_pixel_byte > PIX_HIGH) begin
      item.pixel = PIX_HIGH;
    end else begin
      item.pixel = in_pixel_byte;
    end
  end

  always_comb begin
    col_nxt = col_r + 10'd1;
    row_nxt = row_r;
    if (row_wrap) begin
      col_nxt = '0;
      row_nxt = frame_wrap ? 8'd0 : row_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 8'd80;
      frame_height_r <= 8'd143;
      all_channels_r <= 1'b1;
      led_auto_r     <= 1'b1;
      col_r          <= '0;
      row_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          REG_ALL_CHANNELS: all_channels_r <= cfg_data[0];
          REG_LED_AUTO:     led_auto_r     <= cfg_data[0];
          default:          ;
        endcase
      end
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  pfd_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (in_valid),
    .item_ready      (item_ready),
    .item            (item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_led_command (out_led_command)
  );

endmodule

[hw/rtl/pfd_emit.sv]
// ----------------------------------------------------------------------------
// pfd_emit
// Holds one framed item and sends its result bytes, one per cycle unless
// out_ready stalls, through an output register.
// ----------------------------------------------------------------------------
module pfd_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  output logic          item_ready,
  input  pfd_pkg::item_t item,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last_of_run,
  output logic [1:0]    out_led_command
);
  import pfd_pkg::*;

  logic                 item_valid_r;
  item_t                item_r;
  logic [NUM_SLOTS-1:0] mask_r;
  logic [NUM_SLOTS-1:0] mask_nxt;
  logic                 out_valid_r;
  logic [7:0]           byte_r;
  logic [7:0]           byte_nxt;
  logic                 last_r;
  logic                 last_nxt;
  led_t                 led_r;
  led_t                 led_nxt;
  logic                 load;
  logic                 take;

  // drop the lowest pending slot
  assign mask_nxt = mask_r & (mask_r - NUM_SLOTS'(1));
  assign last_nxt = (mask_nxt == '0);
  assign load     = item_valid_r && (!out_valid_r || out_ready);
  assign item_ready = !item_valid_r || (load && last_nxt);
  assign take     = item_valid && item_ready;

  always_comb begin
    led_nxt = LED_NONE;
    priority if (mask_r[SLOT_FRAME]) begin
      byte_nxt = MARK_FRAME;
    end else if (mask_r[SLOT_WIDTH]) begin
      byte_nxt = item_r.width;
    end else if (mask_r[SLOT_HEIGHT]) begin
      byte_nxt = item_r.height;
    end else if (mask_r[SLOT_ROW]) begin
      byte_nxt = MARK_ROW;
      led_nxt  = item_r.row_led;
    end else if (mask_r[SLOT_PIXEL]) begin
      byte_nxt = item_r.pixel;
    end else begin
      byte_nxt = MARK_END;
      led_nxt  = LED_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        item_valid_r <= 1'b1;
      end else if (load && last_nxt) begin
        item_valid_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item;
      mask_r <= item.slots;
    end else if (load) begin
      mask_r <= mask_nxt;
    end
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      led_r  <= led_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;
  assign out_led_command = led_r;

endmodule

[tb/tb_pixel_frame_dump_framer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_frame_dump_framer
// Self-checking bench for the frame dump framer. Pixel bytes go in through a
// queue-fed driver, a scoreboard predicts the framed byte stream (header, row
// markers with LED commands, clamped pixels, end marker) and a monitor checks
// every output transfer. Register settings change between phases, some of
// them in mid-frame, and both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_pixel_frame_dump_framer;
  import pfd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 84;

  typedef struct {
    logic [7:0] data;
    logic       last;
    led_t       led;
  } link_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_pixel_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic [1:0] out_led_command;

  // scoreboard copy of the registers and the framing counters
  logic [7:0] sb_width = 8'd80;
  logic [7:0] sb_height = 8'd143;
  logic       sb_all_ch = 1'b1;
  logic       sb_led_auto = 1'b1;
  int         sb_col = 0;
  int         sb_row = 0;

  logic [7:0] pixel_q[$];
  link_byte_t link_q[$];

  logic in_calm = 1'b0;
  logic out_calm = 1'b0;
  int   in_gap = 0;
  int   out_stall = 0;
  int   error_count = 0;
  int   result_count = 0;
  int   cycle_count = 0;

  pixel_frame_dump_framer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_byte   (in_pixel_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_led_command (out_led_command)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap(input logic calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  function automatic link_byte_t link_byte(input logic [7:0] data, input led_t led);
    link_byte_t b;
    b.data = data;
    b.last = 1'b0;
    b.led  = led;
    return b;
  endfunction

  // expected serial bytes for one accepted pixel byte
  task automatic frame_pixel(input logic [7:0] raw);
    logic [7:0] w;
    logic [7:0] h;
    logic [7:0] px;
    int         row_len;
    led_t       led;
    w = (sb_width == 8'd0) ? 8'd1 : sb_width;
    h = (sb_height == 8'd0) ? 8'd1 : sb_height;
    row_len = sb_all_ch ? int'(w) * 3 : int'(w);
    if (sb_col == 0 && sb_row == 0) begin
      link_q.push_back(link_byte(MARK_FRAME, LED_NONE));
      link_q.push_back(link_byte(w, LED_NONE));
      link_q.push_back(link_byte(h, LED_NONE));
    end
    if (sb_col == 0) begin
      led = LED_NONE;
      if (sb_led_auto) led = (sb_row % 4 == 0) ? LED_ON : LED_OFF;
      link_q.push_back(link_byte(MARK_ROW, led));
    end
    if (raw < PIX_LOW) px = PIX_LOW;
    else if (raw > PIX_HIGH) px = PIX_HIGH;
    else px = raw;
    link_q.push_back(link_byte(px, LED_NONE));
    // shrunk registers can leave the counters past the new end
    if (sb_col + 1 >= row_len) begin
      sb_col = 0;
      if (sb_row + 1 >= int'(h)) begin
        sb_row = 0;
        link_q.push_back(link_byte(MARK_END, LED_OFF));
      end else begin
        sb_row = sb_row + 1;
      end
    end else begin
      sb_col = sb_col + 1;
    end
    link_q[link_q.size()-1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch in %s of output byte %0d: got %0d, expected %0d",
             $time, field, result_count, got, want);
    error_count++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FRAME_WIDTH:  sb_width = val;
      REG_FRAME_HEIGHT: sb_height = val;
      REG_ALL_CHANNELS: sb_all_ch = val[0];
      REG_LED_AUTO:     sb_led_auto = val[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input logic [7:0] w, input logic [7:0] h,
                           input logic all_ch, input logic led_auto);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_ALL_CHANNELS, {7'd0, all_ch});
    write_reg(REG_LED_AUTO, {7'd0, led_auto});
    end_writes();
  endtask

  // wait until every queued byte is through and the output side has drained;
  // sampled at the falling edge so that the driver's updates have landed
  task automatic settle();
    while (pixel_q.size() != 0 || in_valid || link_q.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [7:0] random_pixel();
    logic [7:0] corner_px[8];
    corner_px = '{8'd0, 8'd15, 8'd16, 8'd17, 8'd239, 8'd240, 8'd241, 8'd255};
    if ($urandom_range(0, 4) == 0) return corner_px[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] random_size(input int top);
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return 8'd255;
    if (r == 1) return 8'd0;
    return 8'($urandom_range(1, top));
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) frame_pixel(in_pixel_byte);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pixel_q.size() != 0) begin
          in_valid      <= 1'b1;
          in_pixel_byte <= pixel_q.pop_front();
          in_gap        <= pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and backpressure
  always @(posedge clk) begin
    link_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (link_q.size() == 0) begin
          report_mismatch("presence", 1, 0);
        end else begin
          want = link_q.pop_front();
          if (out_byte !== want.data) report_mismatch("byte", out_byte, want.data);
          if (out_last_of_run !== want.last)
            report_mismatch("last_of_run", out_last_of_run, want.last);
          if (out_led_command !== want.led)
            report_mismatch("led_command", out_led_command, want.led);
        end
        result_count++;
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        out_stall <= pick_gap(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int sent;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: header, first row marker and the clamp corners
    pixel_q = '{8'd0, 8'd15, 8'd16, 8'd17, 8'd239, 8'd240, 8'd241, 8'd255};
    settle();

    // one-pixel frames, zero height read as one, no LED; first byte cuts
    // the long row short and closes the frame
    set_frame(8'd1, 8'd0, 1'b0, 1'b0);
    pixel_q = '{8'd100, 8'd7};
    settle();

    // zero width read as one, five rows: LED on for rows 0 and 4
    set_frame(8'd0, 8'd5, 1'b0, 1'b1);
    pixel_q = '{8'd1, 8'd128, 8'd250, 8'd16, 8'd240};
    settle();

    // largest sizes, three bytes per pixel
    set_frame(8'd255, 8'd255, 1'b1, 1'b1);
    pixel_q = '{8'd255, 8'd0, 8'd170};
    settle();

    // random phases, settings changed while frames may still be open
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_WIDTH, random_size(4));
      if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_HEIGHT, random_size(9));
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_ALL_CHANNELS, {7'd0, 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_LED_AUTO, {7'd0, 1'($urandom_range(0, 1))});
      end_writes();
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(4, 18);
      repeat (n) pixel_q.push_back(random_pixel());
      sent += n;
      settle();
    end

    settle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pfd_pkg.sv
hw/rtl/pfd_emit.sv
hw/rtl/pixel_frame_dump_framer.sv
tb/tb_pixel_frame_dump_framer.sv
